FILE: rtl/core/mmh_pkg.sv
package mmh_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 13;
    localparam int DIV_DW = 40;
    localparam int DIV_VW = 33;

    localparam logic [5:0] CFG_BC_RESET = 6'd63;
    localparam logic [7:0] CFG_MH_RESET = 8'd200;

    localparam logic CFG_BIN_COUNT  = 1'b0;
    localparam logic CFG_MAX_HEIGHT = 1'b1;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_BIN_RD,
        ST_BIN_MUL,
        ST_BIN_DIV,
        ST_BIN_DWAIT,
        ST_BIN_CRD,
        ST_BIN_CWR,
        ST_EDGE_DIV,
        ST_EDGE_DWAIT,
        ST_EDGE_INIT,
        ST_MM_RD,
        ST_MM_CMP,
        ST_EMIT_RD,
        ST_EMIT_MUL,
        ST_EMIT_DIV,
        ST_EMIT_DWAIT,
        ST_EMIT_OUT,
        ST_EMIT_WAIT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic load;
        logic val_rd;
        logic mul_bin;
        logic div_bin_start;
        logic cnt_rd_bin;
        logic cnt_wr;
        logic item_step;
        logic div_edge_start;
        logic edge_init;
        logic mm_rd;
        logic mm_cmp;
        logic emit_rd;
        logic emit_mul;
        logic div_bar_start;
        logic out_load;
        logic edge_step;
        logic bin_step;
        logic run_clear;
    } cmd_t;

    typedef struct packed {
        logic item_last;
        logic bin_last;
        logic range_zero;
        logic frange_zero;
        logic div_busy;
        logic out_done;
    } sts_t;

endpackage

FILE: rtl/core/mmh_ram.sv
module mmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mmh_div.sv
module mmh_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [mmh_pkg::DIV_DW-1:0] dividend,
    input  logic [mmh_pkg::DIV_VW-1:0] divisor,
    output logic                       busy,
    output logic [mmh_pkg::DIV_DW-1:0] quotient,
    output logic [mmh_pkg::DIV_VW-1:0] remainder
);

    localparam int DW = mmh_pkg::DIV_DW;
    localparam int VW = mmh_pkg::DIV_VW;
    localparam int SW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic          busy_reg, busy_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    // One quotient bit per cycle, most significant first.
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        steps_next = steps_reg;
        busy_next  = busy_reg;
        if (start) begin
            quo_next   = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
            steps_next = SW'(DW);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            quo_next   = {quo_reg[DW-2:0], fits};
            rem_next   = fits ? diff[VW-1:0] : trial[VW-1:0];
            steps_next = steps_reg - 1'b1;
            busy_next  = steps_reg != SW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            steps_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            steps_reg <= steps_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/core/mmh_datapath.sv
module mmh_datapath #(
    parameter int MAX_ITEMS = 4096,
    parameter int MAX_BINS  = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mmh_pkg::cmd_t             cmd,
    output mmh_pkg::sts_t             sts,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [7:0]                cfg_wdata,
    input  logic [31:0]               s_length_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [5:0]                m_bin_index,
    output logic [31:0]               m_bin_low_edge,
    output logic [12:0]               m_bin_total,
    output logic [7:0]                m_bar_length,
    output logic [12:0]               m_least_frequency,
    output logic [12:0]               m_greatest_frequency,
    output logic                      m_overflowed,
    output logic                      m_last_bin
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int BW = $clog2(MAX_BINS);
    localparam int VW = mmh_pkg::VAL_W;
    localparam int NW = mmh_pkg::CNT_W;
    localparam int DW = mmh_pkg::DIV_DW;
    localparam int QW = mmh_pkg::DIV_VW;
    localparam int PW = VW + BW;

    logic [5:0]    bc_cfg_reg;
    logic [7:0]    mh_cfg_reg;
    logic [CW-1:0] count_reg;
    logic [VW-1:0] min_reg;
    logic [VW-1:0] max_reg;
    logic          drop_reg;
    logic [MAX_BINS-1:0] valid_reg;
    logic          valid_rd_reg;
    logic [CW-1:0] item_reg;
    logic [BW-1:0] bin_reg;
    logic [BW-1:0] hit_reg;
    logic [PW-1:0] prod_reg;
    logic [NW-1:0] cnt_reg;
    logic [NW+7:0] num_reg;
    logic [NW-1:0] minc_reg;
    logic [NW-1:0] maxc_reg;
    logic [31:0]   qacc_reg;
    logic [6:0]    racc_reg;
    logic [31:0]   qstep_reg;
    logic [6:0]    rstep_reg;

    logic          out_valid_reg;
    logic [BW-1:0] out_bin_reg;
    logic [31:0]   out_edge_reg;
    logic [NW-1:0] out_total_reg;
    logic [7:0]    out_bar_reg;
    logic [NW-1:0] out_minc_reg;
    logic [NW-1:0] out_maxc_reg;
    logic          out_ovf_reg;
    logic          out_last_reg;

    logic [BW-1:0] bc;
    logic [7:0]    scale;
    logic [VW-1:0] range;
    logic [NW-1:0] frange;
    logic          full;
    logic [VW-1:0] val_rdata;
    logic [NW-1:0] bin_rdata;
    logic [NW-1:0] cnt_now;
    logic [BW-1:0] idx_now;
    logic [BW-1:0] bin_raddr;
    logic          div_start;
    logic [DW-1:0] div_dvd;
    logic [QW-1:0] div_dsr;
    logic          div_busy;
    logic [DW-1:0] div_q;
    logic [QW-1:0] div_r;
    logic [6:0]    two_bc;
    logic [7:0]    rsum;

    // Bin count zero counts as one; above the bin store it is held at the top.
    always_comb begin
        if (bc_cfg_reg == 6'd0) begin
            bc = BW'(1);
        end else if ({1'b0, bc_cfg_reg} > 7'(MAX_BINS - 1)) begin
            bc = BW'(MAX_BINS - 1);
        end else begin
            bc = BW'(bc_cfg_reg);
        end
    end

    assign scale   = (mh_cfg_reg >= 8'd1) ? mh_cfg_reg - 8'd1 : 8'd0;
    assign range   = max_reg - min_reg;
    assign frange  = maxc_reg - minc_reg;
    assign full    = count_reg == CW'(MAX_ITEMS);
    assign cnt_now = valid_rd_reg ? bin_rdata : '0;
    assign two_bc  = 7'(bc) << 1;
    assign rsum    = {1'b0, racc_reg} + {1'b0, rstep_reg};

    always_comb begin
        if (range == '0) begin
            idx_now = '0;
        end else if (div_q > DW'(bc)) begin
            idx_now = bc;
        end else begin
            idx_now = div_q[BW-1:0];
        end
    end

    assign bin_raddr = cmd.cnt_rd_bin ? idx_now : bin_reg;

    mmh_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_value_ram (
        .aclk  (aclk),
        .we    (cmd.load && !full),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_length_value),
        .raddr (item_reg[AW-1:0]),
        .rdata (val_rdata)
    );

    mmh_ram #(.WIDTH(NW), .DEPTH(MAX_BINS)) u_bin_ram (
        .aclk  (aclk),
        .we    (cmd.cnt_wr),
        .waddr (hit_reg),
        .wdata (cnt_now + NW'(1)),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    // The shared divider serves bin placement, the edge step and the bar scale.
    assign div_start = cmd.div_bin_start || cmd.div_edge_start || cmd.div_bar_start;

    always_comb begin
        if (cmd.div_edge_start) begin
            div_dvd = DW'(range);
            div_dsr = QW'(bc);
        end else if (cmd.div_bar_start) begin
            div_dvd = DW'(num_reg) + DW'(frange) - DW'(1);
            div_dsr = QW'(frange);
        end else begin
            div_dvd = (DW'(prod_reg) << 1) + DW'(range);
            div_dsr = QW'(range) << 1;
        end
    end

    mmh_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_cfg_reg    <= mmh_pkg::CFG_BC_RESET;
            mh_cfg_reg    <= mmh_pkg::CFG_MH_RESET;
            count_reg     <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            drop_reg      <= 1'b0;
            valid_reg     <= '0;
            item_reg      <= '0;
            bin_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mmh_pkg::CFG_BIN_COUNT:  bc_cfg_reg <= cfg_wdata[5:0];
                    mmh_pkg::CFG_MAX_HEIGHT: mh_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                if (full) begin
                    drop_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                    if (s_length_value < min_reg) begin
                        min_reg <= s_length_value;
                    end
                    if (s_length_value > max_reg) begin
                        max_reg <= s_length_value;
                    end
                end
            end
            if (cmd.cnt_wr) begin
                valid_reg[hit_reg] <= 1'b1;
            end
            if (cmd.item_step) begin
                item_reg <= item_reg + CW'(1);
            end
            if (cmd.bin_step) begin
                bin_reg <= (bin_reg == bc) ? '0 : bin_reg + BW'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.run_clear) begin
                count_reg <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
                drop_reg  <= 1'b0;
                valid_reg <= '0;
                item_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        valid_rd_reg <= valid_reg[bin_raddr];
        if (cmd.mul_bin) begin
            prod_reg <= PW'(val_rdata - min_reg) * PW'(bc);
        end
        if (cmd.cnt_rd_bin) begin
            hit_reg <= idx_now;
        end
        if (cmd.mm_cmp) begin
            if (bin_reg == '0) begin
                minc_reg <= cnt_now;
                maxc_reg <= cnt_now;
            end else begin
                if (cnt_now < minc_reg) begin
                    minc_reg <= cnt_now;
                end
                if (cnt_now > maxc_reg) begin
                    maxc_reg <= cnt_now;
                end
            end
        end
        if (cmd.emit_mul) begin
            cnt_reg <= cnt_now;
            num_reg <= (NW + 8)'(cnt_now - minc_reg) * (NW + 8)'(scale);
        end
        // Edge i is min + floor((2*i*range + bc) / (2*bc)), kept as a running
        // quotient and remainder that advance by range/bc each bin.
        if (cmd.edge_init) begin
            qacc_reg  <= '0;
            racc_reg  <= 7'(bc);
            qstep_reg <= div_q[31:0];
            rstep_reg <= 7'(div_r[5:0]) << 1;
        end
        if (cmd.edge_step) begin
            if (rsum >= {1'b0, two_bc}) begin
                racc_reg <= 7'(rsum - {1'b0, two_bc});
                qacc_reg <= qacc_reg + qstep_reg + 32'd1;
            end else begin
                racc_reg <= rsum[6:0];
                qacc_reg <= qacc_reg + qstep_reg;
            end
        end
        if (cmd.out_load) begin
            out_bin_reg   <= bin_reg;
            out_edge_reg  <= min_reg + qacc_reg;
            out_total_reg <= cnt_reg;
            out_bar_reg   <= (frange == '0) ? 8'd0 : div_q[7:0];
            out_minc_reg  <= minc_reg;
            out_maxc_reg  <= maxc_reg;
            out_ovf_reg   <= drop_reg;
            out_last_reg  <= bin_reg == bc;
        end
    end

    assign sts.item_last   = item_reg == count_reg - CW'(1);
    assign sts.bin_last    = bin_reg == bc;
    assign sts.range_zero  = range == '0;
    assign sts.frange_zero = frange == '0;
    assign sts.div_busy    = div_busy;
    assign sts.out_done    = out_valid_reg && m_ready;

    assign m_valid              = out_valid_reg;
    assign m_bin_index          = 6'(out_bin_reg);
    assign m_bin_low_edge       = out_edge_reg;
    assign m_bin_total          = out_total_reg;
    assign m_bar_length         = out_bar_reg;
    assign m_least_frequency    = out_minc_reg;
    assign m_greatest_frequency = out_maxc_reg;
    assign m_overflowed         = out_ovf_reg;
    assign m_last_bin           = out_last_reg;

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ITEMS))
        else $error("stored count beyond capacity");

    a_out_bin_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_bin_reg <= bc)
        else $error("reported bin beyond bin count");

endmodule

FILE: rtl/core/mmh_ctrl.sv
module mmh_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_last_item,
    output logic          s_ready,
    input  mmh_pkg::sts_t sts,
    output mmh_pkg::cmd_t cmd
);

    mmh_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mmh_pkg::ST_LOAD: begin
                if (s_valid && s_last_item) begin
                    state_next = mmh_pkg::ST_BIN_RD;
                end
            end
            mmh_pkg::ST_BIN_RD:  state_next = mmh_pkg::ST_BIN_MUL;
            mmh_pkg::ST_BIN_MUL: state_next = mmh_pkg::ST_BIN_DIV;
            mmh_pkg::ST_BIN_DIV: begin
                state_next = sts.range_zero ? mmh_pkg::ST_BIN_CRD : mmh_pkg::ST_BIN_DWAIT;
            end
            mmh_pkg::ST_BIN_DWAIT: begin
                if (!sts.div_busy) begin
                    state_next = mmh_pkg::ST_BIN_CRD;
                end
            end
            mmh_pkg::ST_BIN_CRD: state_next = mmh_pkg::ST_BIN_CWR;
            mmh_pkg::ST_BIN_CWR: begin
                state_next = sts.item_last ? mmh_pkg::ST_EDGE_DIV : mmh_pkg::ST_BIN_RD;
            end
            mmh_pkg::ST_EDGE_DIV: state_next = mmh_pkg::ST_EDGE_DWAIT;
            mmh_pkg::ST_EDGE_DWAIT: begin
                if (!sts.div_busy) begin
                    state_next = mmh_pkg::ST_EDGE_INIT;
                end
            end
            mmh_pkg::ST_EDGE_INIT: state_next = mmh_pkg::ST_MM_RD;
            mmh_pkg::ST_MM_RD:     state_next = mmh_pkg::ST_MM_CMP;
            mmh_pkg::ST_MM_CMP: begin
                state_next = sts.bin_last ? mmh_pkg::ST_EMIT_RD : mmh_pkg::ST_MM_RD;
            end
            mmh_pkg::ST_EMIT_RD:  state_next = mmh_pkg::ST_EMIT_MUL;
            mmh_pkg::ST_EMIT_MUL: state_next = mmh_pkg::ST_EMIT_DIV;
            mmh_pkg::ST_EMIT_DIV: begin
                state_next = sts.frange_zero ? mmh_pkg::ST_EMIT_OUT : mmh_pkg::ST_EMIT_DWAIT;
            end
            mmh_pkg::ST_EMIT_DWAIT: begin
                if (!sts.div_busy) begin
                    state_next = mmh_pkg::ST_EMIT_OUT;
                end
            end
            mmh_pkg::ST_EMIT_OUT: state_next = mmh_pkg::ST_EMIT_WAIT;
            mmh_pkg::ST_EMIT_WAIT: begin
                if (sts.out_done) begin
                    state_next = sts.bin_last ? mmh_pkg::ST_CLEAR : mmh_pkg::ST_EMIT_RD;
                end
            end
            mmh_pkg::ST_CLEAR: state_next = mmh_pkg::ST_LOAD;
            default:           state_next = mmh_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            mmh_pkg::ST_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            mmh_pkg::ST_BIN_RD:  cmd.val_rd = 1'b1;
            mmh_pkg::ST_BIN_MUL: cmd.mul_bin = 1'b1;
            mmh_pkg::ST_BIN_DIV: cmd.div_bin_start = !sts.range_zero;
            mmh_pkg::ST_BIN_CRD: cmd.cnt_rd_bin = 1'b1;
            mmh_pkg::ST_BIN_CWR: begin
                cmd.cnt_wr    = 1'b1;
                cmd.item_step = 1'b1;
            end
            mmh_pkg::ST_EDGE_DIV:  cmd.div_edge_start = 1'b1;
            mmh_pkg::ST_EDGE_INIT: cmd.edge_init = 1'b1;
            mmh_pkg::ST_MM_RD:     cmd.mm_rd = 1'b1;
            mmh_pkg::ST_MM_CMP: begin
                cmd.mm_cmp   = 1'b1;
                cmd.bin_step = 1'b1;
            end
            mmh_pkg::ST_EMIT_RD:  cmd.emit_rd = 1'b1;
            mmh_pkg::ST_EMIT_MUL: cmd.emit_mul = 1'b1;
            mmh_pkg::ST_EMIT_DIV: cmd.div_bar_start = !sts.frange_zero;
            mmh_pkg::ST_EMIT_OUT: cmd.out_load = 1'b1;
            mmh_pkg::ST_EMIT_WAIT: begin
                cmd.edge_step = sts.out_done;
                cmd.bin_step  = sts.out_done;
            end
            mmh_pkg::ST_CLEAR: cmd.run_clear = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mmh_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/minmax_binned_histogram.sv
// Min/max normalized histogram over unsigned Q16.16 values. Values are taken
// one word per cycle into a value store of MAX_ITEMS entries while the running
// minimum and maximum are tracked; values beyond capacity are dropped and the
// overflowed flag of the run is set. The word marked last_item ends the data
// set: no further input is taken until the run has been reported. Each stored
// value is then placed in bin round((v - min) * B / (max - min)), where B is
// the bin_count register (zero counts as one, values above MAX_BINS - 1 are
// held there), the smallest and largest bin totals are found, and B + 1 result
// words go out, lowest bin first, each carrying the bin's lower edge, its
// total and a bar length scaled to max_height - 1 and rounded up. A zero value
// range puts every value in bin 0, and equal totals give bars of 0.
// After the last value, the stored values are placed one after another, each
// quotient going through the single 40-step serial divider; then the edge
// step is set up, the bin totals are scanned, and each result word is held
// until m_ready. A clear state at the end resets the run state before loading
// resumes. The user must write the registers only while the block is idle;
// the block itself does not enforce this.
module minmax_binned_histogram #(
    parameter int MAX_ITEMS = 4096,
    parameter int MAX_BINS  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_length_value,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_bin_index,
    output logic [31:0] m_bin_low_edge,
    output logic [12:0] m_bin_total,
    output logic [7:0]  m_bar_length,
    output logic [12:0] m_least_frequency,
    output logic [12:0] m_greatest_frequency,
    output logic        m_overflowed,
    output logic        m_last_bin
);

    // The controller sequences the phases; the datapath holds the stores,
    // the shared divider and the result register.
    mmh_pkg::cmd_t cmd;
    mmh_pkg::sts_t sts;

    mmh_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_item (s_last_item),
        .s_ready     (s_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    mmh_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_BINS  (MAX_BINS)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .sts                  (sts),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_length_value       (s_length_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_bin_index          (m_bin_index),
        .m_bin_low_edge       (m_bin_low_edge),
        .m_bin_total          (m_bin_total),
        .m_bar_length         (m_bar_length),
        .m_least_frequency    (m_least_frequency),
        .m_greatest_frequency (m_greatest_frequency),
        .m_overflowed         (m_overflowed),
        .m_last_bin           (m_last_bin)
    );

endmodule
